// ===== rtl/lcrm_pkg.sv =====
`timescale 1ns / 1ps

package lcrm_pkg;

   localparam int MAX_ENTRIES_DEF = 64;
   localparam int COORD_BITS_DEF  = 20;

   // Radius and count field widths are fixed by the item format.
   localparam int RAD_W    = 16;
   localparam int CNT_BITS = 16;

   localparam logic [RAD_W-1:0]    RADIUS_RESET = 16'd459;
   localparam logic [CNT_BITS-1:0] COUNT_MAX    = 16'hFFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MUL,
      ST_PREP,
      ST_DIV,
      ST_WRITE
   } state_type;

   typedef enum logic [1:0] {
      OUT_MERGE = 2'd0,
      OUT_NEW   = 2'd1,
      OUT_DROP  = 2'd2
   } outcome_type;

endpackage

// ===== rtl/leader_cluster_running_mean_unit.sv =====
// The entry memory is searched one read per cycle through a three-stage compare pipeline,
// and a merge then runs a restoring divide of one quotient bit per cycle on x and y together.
// One item is in work at a time; the next is accepted the cycle after the result is registered.
// Reset (synchronous) clears the table counts and sets the radius to 459; entry memory is not cleared.
`timescale 1ns / 1ps

module leader_cluster_running_mean_unit
   import lcrm_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int COORD_BITS  = COORD_BITS_DEF,
   localparam int IDX_W      = $clog2(MAX_ENTRIES)
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   input  logic                         req_last_in_batch,

   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_outcome,
   output logic [IDX_W-1:0]             rsp_entry_index,
   output logic signed [COORD_BITS-1:0] rsp_entry_x,
   output logic signed [COORD_BITS-1:0] rsp_entry_y,
   output logic [CNT_BITS-1:0]          rsp_merge_count,

   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [RAD_W-1:0]             csr_match_radius
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int DW    = COORD_BITS + 1;
   localparam int EXT_W = DW + RAD_W;
   localparam int SQ_W  = 2 * RAD_W;
   localparam int SS_W  = SQ_W + 1;
   localparam int PW    = COORD_BITS + CNT_BITS + 1;
   localparam int MW    = COORD_BITS + CNT_BITS;
   localparam int QD_W  = CNT_BITS + 1;
   localparam int TX_W  = QD_W + 1;
   localparam int DC_W  = $clog2(COORD_BITS);

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [CNT_BITS-1:0]   count;
   } entry_type;

   state_type state_ff, state_in;

   logic [RAD_W-1:0] radius_ff;
   logic [SQ_W-1:0]  rsq_ff;

   logic signed [COORD_BITS-1:0] px_ff, py_ff;
   logic                         last_ff;

   logic [CNT_W-1:0] committed_ff, allocated_ff, rd_cnt_ff;

   entry_type mem [0:MAX_ENTRIES-1];
   entry_type mem_q_ff;
   logic [IDX_W-1:0] q_idx_ff;
   logic             v0_ff, v1_ff, v2_ff;

   logic [IDX_W-1:0] s1_idx_ff, s2_idx_ff;
   entry_type        s1_ent_ff, s2_ent_ff;
   logic [RAD_W-1:0] ax1_ff, ay1_ff;
   logic             near1_ff, near2_ff;
   logic [SQ_W-1:0]  sqx2_ff, sqy2_ff;

   logic [IDX_W-1:0] hit_idx_ff;
   entry_type        hit_ent_ff;
   outcome_type      kind_ff;

   logic signed [PW-1:0]  sumx_ff, sumy_ff;
   logic [CNT_BITS-1:0]   cnt_new_ff;
   logic [QD_W-1:0]       remx_ff, remy_ff;
   logic [COORD_BITS-1:0] quox_ff, quoy_ff;
   logic                  negx_ff, negy_ff;
   logic [DC_W-1:0]       div_cnt_ff;

   logic                         rsp_valid_ff;
   outcome_type                  rsp_outcome_ff;
   logic [IDX_W-1:0]             rsp_index_ff;
   logic signed [COORD_BITS-1:0] rsp_x_ff, rsp_y_ff;
   logic [CNT_BITS-1:0]          rsp_count_ff;

   // Combinational signals
   logic                  req_take, rd_en, search_hit, search_miss, out_free, finish;
   logic                  mem_we;
   entry_type             wr_data;
   logic signed [DW-1:0]  dx, dy;
   logic [DW-1:0]         adx, ady;
   logic                  near0;
   logic [SS_W-1:0]       dist_sq;
   logic [CNT_BITS-1:0]   c_sat;
   logic [PW-1:0]         magx, magy;
   logic [QD_W-1:0]       divisor;
   logic [TX_W-1:0]       tx, ty;
   logic                  gex, gey;
   logic [COORD_BITS-1:0] resx, resy;
   logic [CNT_W-1:0]      alloc_next;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Compare pipeline, stage one: distance per axis and the box test.
   assign dx    = DW'($signed(mem_q_ff.x)) - DW'(px_ff);
   assign dy    = DW'($signed(mem_q_ff.y)) - DW'(py_ff);
   assign adx   = dx[DW-1] ? DW'(-dx) : DW'(dx);
   assign ady   = dy[DW-1] ? DW'(-dy) : DW'(dy);
   assign near0 = (EXT_W'(adx) < EXT_W'(radius_ff)) && (EXT_W'(ady) < EXT_W'(radius_ff));

   assign dist_sq    = SS_W'(sqx2_ff) + SS_W'(sqy2_ff);
   assign search_hit = (state_ff == ST_SEARCH) && v2_ff && near2_ff
                       && (dist_sq < SS_W'(rsq_ff));
   assign rd_en      = (state_ff == ST_SEARCH) && (rd_cnt_ff < committed_ff) && !search_hit;
   assign search_miss = (state_ff == ST_SEARCH) && (rd_cnt_ff >= committed_ff)
                        && !v0_ff && !v1_ff && !v2_ff;

   // Merge arithmetic: weighted sum, magnitude, and one restoring divide step per axis.
   assign c_sat   = (hit_ent_ff.count == COUNT_MAX) ? COUNT_MAX : hit_ent_ff.count + 1'b1;
   assign magx    = sumx_ff[PW-1] ? PW'(-sumx_ff) : PW'(sumx_ff);
   assign magy    = sumy_ff[PW-1] ? PW'(-sumy_ff) : PW'(sumy_ff);
   assign divisor = QD_W'(cnt_new_ff) + QD_W'(1);
   assign tx      = {remx_ff, quox_ff[COORD_BITS-1]};
   assign ty      = {remy_ff, quoy_ff[COORD_BITS-1]};
   assign gex     = (tx >= TX_W'(divisor));
   assign gey     = (ty >= TX_W'(divisor));
   assign resx    = negx_ff ? COORD_BITS'(-quox_ff) : quox_ff;
   assign resy    = negy_ff ? COORD_BITS'(-quoy_ff) : quoy_ff;

   assign finish     = (state_ff == ST_WRITE) && out_free;
   assign mem_we     = finish && (kind_ff != OUT_DROP);
   assign alloc_next = (kind_ff == OUT_NEW) ? allocated_ff + 1'b1 : allocated_ff;

   always_comb begin
      wr_data = '0;
      if (kind_ff == OUT_NEW) begin
         wr_data.x = px_ff;
         wr_data.y = py_ff;
      end else begin
         wr_data.x     = resx;
         wr_data.y     = resy;
         wr_data.count = cnt_new_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (search_hit) begin
               state_in = ST_MUL;
            end else if (search_miss) begin
               state_in = ST_WRITE;
            end
         end
         ST_MUL:  state_in = ST_PREP;
         ST_PREP: state_in = ST_DIV;
         ST_DIV: begin
            if (div_cnt_ff == '0) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= RADIUS_RESET;
         committed_ff <= '0;
         allocated_ff <= '0;
         rd_cnt_ff    <= '0;
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) radius_ff <= csr_match_radius;
         if (req_take) begin
            rd_cnt_ff <= '0;
         end else if (rd_en) begin
            rd_cnt_ff <= rd_cnt_ff + 1'b1;
         end
         v0_ff <= rd_en;
         v1_ff <= v0_ff && (state_ff == ST_SEARCH) && !search_hit;
         v2_ff <= v1_ff && (state_ff == ST_SEARCH) && !search_hit;
         if (finish) begin
            allocated_ff <= alloc_next;
            if (last_ff) committed_ff <= alloc_next;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Entry memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) mem[hit_idx_ff] <= wr_data;
      if (rd_en) mem_q_ff <= mem[rd_cnt_ff[IDX_W-1:0]];
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         px_ff   <= req_point_x;
         py_ff   <= req_point_y;
         last_ff <= req_last_in_batch;
         rsq_ff  <= SQ_W'(radius_ff) * SQ_W'(radius_ff);
      end

      q_idx_ff  <= rd_cnt_ff[IDX_W-1:0];
      s1_idx_ff <= q_idx_ff;
      s1_ent_ff <= mem_q_ff;
      ax1_ff    <= RAD_W'(adx);
      ay1_ff    <= RAD_W'(ady);
      near1_ff  <= near0;
      s2_idx_ff <= s1_idx_ff;
      s2_ent_ff <= s1_ent_ff;
      sqx2_ff   <= SQ_W'(ax1_ff) * SQ_W'(ax1_ff);
      sqy2_ff   <= SQ_W'(ay1_ff) * SQ_W'(ay1_ff);
      near2_ff  <= near1_ff;

      if (search_hit) begin
         hit_idx_ff <= s2_idx_ff;
         hit_ent_ff <= s2_ent_ff;
         kind_ff    <= OUT_MERGE;
      end else if (search_miss) begin
         hit_idx_ff <= allocated_ff[IDX_W-1:0];
         kind_ff    <= (allocated_ff < CNT_W'(MAX_ENTRIES)) ? OUT_NEW : OUT_DROP;
      end

      if (state_ff == ST_MUL) begin
         cnt_new_ff <= c_sat;
         sumx_ff    <= PW'($signed({1'b0, c_sat})) * PW'($signed(hit_ent_ff.x)) + PW'(px_ff);
         sumy_ff    <= PW'($signed({1'b0, c_sat})) * PW'($signed(hit_ent_ff.y)) + PW'(py_ff);
      end

      // The quotient fits COORD_BITS bits, so the top part of the dividend starts as remainder.
      if (state_ff == ST_PREP) begin
         negx_ff    <= sumx_ff[PW-1];
         negy_ff    <= sumy_ff[PW-1];
         remx_ff    <= QD_W'(magx[MW-1:COORD_BITS]);
         remy_ff    <= QD_W'(magy[MW-1:COORD_BITS]);
         quox_ff    <= magx[COORD_BITS-1:0];
         quoy_ff    <= magy[COORD_BITS-1:0];
         div_cnt_ff <= DC_W'(COORD_BITS - 1);
      end else if (state_ff == ST_DIV) begin
         remx_ff    <= gex ? QD_W'(tx - TX_W'(divisor)) : QD_W'(tx);
         remy_ff    <= gey ? QD_W'(ty - TX_W'(divisor)) : QD_W'(ty);
         quox_ff    <= {quox_ff[COORD_BITS-2:0], gex};
         quoy_ff    <= {quoy_ff[COORD_BITS-2:0], gey};
         div_cnt_ff <= div_cnt_ff - 1'b1;
      end

      if (finish) begin
         rsp_outcome_ff <= kind_ff;
         unique case (kind_ff)
            OUT_MERGE: begin
               rsp_index_ff <= hit_idx_ff;
               rsp_x_ff     <= resx;
               rsp_y_ff     <= resy;
               rsp_count_ff <= cnt_new_ff;
            end
            OUT_NEW: begin
               rsp_index_ff <= hit_idx_ff;
               rsp_x_ff     <= px_ff;
               rsp_y_ff     <= py_ff;
               rsp_count_ff <= '0;
            end
            default: begin
               rsp_index_ff <= '0;
               rsp_x_ff     <= '0;
               rsp_y_ff     <= '0;
               rsp_count_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_outcome     = rsp_outcome_ff;
   assign rsp_entry_index = rsp_index_ff;
   assign rsp_entry_x     = rsp_x_ff;
   assign rsp_entry_y     = rsp_y_ff;
   assign rsp_merge_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_commit_le_alloc: assert property (@(posedge clock) disable iff (reset)
      committed_ff <= allocated_ff)
      else $error("committed entries exceed allocated entries");

   a_alloc_bound: assert property (@(posedge clock) disable iff (reset)
      allocated_ff <= CNT_W'(MAX_ENTRIES))
      else $error("allocated entries exceed table size");

   a_hit_committed: assert property (@(posedge clock) disable iff (reset)
      search_hit |-> (CNT_W'(s2_idx_ff) < committed_ff))
      else $error("match found on an entry that is not committed");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      finish && (kind_ff == OUT_DROP) |=> (rsp_entry_index == '0) && (rsp_merge_count == '0))
      else $error("dropped item carries nonzero fields");
`endif

endmodule

// ===== tb/sv/cluster_table_checker.sv =====
`timescale 1ns / 1ps

module cluster_table_checker
   import lcrm_pkg::*;
(
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic signed [COORD_BITS_DEF-1:0]     req_point_x,
   input  logic signed [COORD_BITS_DEF-1:0]     req_point_y,
   input  logic                                 req_last_in_batch,

   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [1:0]                           rsp_outcome,
   input  logic [$clog2(MAX_ENTRIES_DEF)-1:0]   rsp_entry_index,
   input  logic signed [COORD_BITS_DEF-1:0]     rsp_entry_x,
   input  logic signed [COORD_BITS_DEF-1:0]     rsp_entry_y,
   input  logic [CNT_BITS-1:0]                  rsp_merge_count,

   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [RAD_W-1:0]                     csr_match_radius,

   output int                                   mismatches,
   output int                                   outstanding
);

   localparam int ENTRIES = MAX_ENTRIES_DEF;
   localparam int XY_W    = COORD_BITS_DEF;
   localparam int IDX_W   = $clog2(ENTRIES);

   typedef struct {
      outcome_type             outcome;
      logic [IDX_W-1:0]        index;
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic [CNT_BITS-1:0]     count;
   } placement_type;

   longint           centroid_x [ENTRIES];
   longint           centroid_y [ENTRIES];
   int unsigned      hits [ENTRIES];
   int               committed;
   int               allocated;
   logic [RAD_W-1:0] radius;
   placement_type    placements_due[$];
   int               errors = 0;
   int               results_seen = 0;

   // Search the committed entries in index order; the first one inside the radius takes
   // the point, otherwise it opens a pending entry or is dropped when the table is full.
   function automatic placement_type place_point(longint px, longint py, bit last);
      placement_type    p;
      longint           dx;
      longint           dy;
      longint unsigned  ax;
      longint unsigned  ay;
      longint unsigned  rr;
      int unsigned      c;
      bit               placed;
      p.outcome = OUT_DROP;
      p.index   = '0;
      p.x       = '0;
      p.y       = '0;
      p.count   = '0;
      placed    = 1'b0;
      rr        = radius;
      for (int i = 0; i < committed && !placed; i++) begin
         dx = centroid_x[i] - px;
         dy = centroid_y[i] - py;
         ax = (dx < 0) ? -dx : dx;
         ay = (dy < 0) ? -dy : dy;
         if (ax < rr && ay < rr && ax * ax + ay * ay < rr * rr) begin
            c = hits[i];
            if (c < COUNT_MAX) c++;
            hits[i] = c;
            // SystemVerilog integer division truncates toward zero.
            centroid_x[i] = (longint'(c) * centroid_x[i] + px) / (longint'(c) + 1);
            centroid_y[i] = (longint'(c) * centroid_y[i] + py) / (longint'(c) + 1);
            p.outcome = OUT_MERGE;
            p.index   = IDX_W'(i);
            p.x       = XY_W'(centroid_x[i]);
            p.y       = XY_W'(centroid_y[i]);
            p.count   = CNT_BITS'(c);
            placed    = 1'b1;
         end
      end
      if (!placed && allocated < ENTRIES) begin
         centroid_x[allocated] = px;
         centroid_y[allocated] = py;
         hits[allocated]       = 0;
         p.outcome = OUT_NEW;
         p.index   = IDX_W'(allocated);
         p.x       = XY_W'(px);
         p.y       = XY_W'(py);
         p.count   = '0;
         allocated++;
      end
      if (last) committed = allocated;
      return p;
   endfunction

   task automatic compare_field(string field, int want, int got);
      if (want != got) begin
         if (errors < 10)
            $display("result %0d: %s expected %0d, got %0d", results_seen, field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      placement_type due;
      if (reset) begin
         committed = 0;
         allocated = 0;
         radius    = RADIUS_RESET;
         placements_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (placements_due.size() == 0) begin
               if (errors < 10)
                  $display("result %0d arrived with no item outstanding", results_seen);
               errors++;
            end else begin
               due = placements_due.pop_front();
               compare_field("outcome", int'(due.outcome), int'(rsp_outcome));
               compare_field("entry_index", int'(due.index), int'(rsp_entry_index));
               compare_field("entry_x", int'(due.x), int'(rsp_entry_x));
               compare_field("entry_y", int'(due.y), int'(rsp_entry_y));
               compare_field("merge_count", int'(due.count), int'(rsp_merge_count));
            end
            results_seen++;
         end
         if (csr_valid && csr_ready) radius = csr_match_radius;
         if (req_valid && req_ready)
            placements_due.push_back(place_point(req_point_x, req_point_y,
                                                 req_last_in_batch));
      end
      mismatches  <= errors;
      outstanding <= placements_due.size();
   end

endmodule

// ===== tb/sv/leader_cluster_running_mean_unit_tb.sv =====
`timescale 1ns / 1ps

module leader_cluster_running_mean_unit_tb;
   import lcrm_pkg::*;

   localparam int XY_W   = COORD_BITS_DEF;
   localparam int IDX_W  = $clog2(MAX_ENTRIES_DEF);
   localparam int XY_MAX = (1 << (XY_W - 1)) - 1;
   localparam int XY_MIN = -(1 << (XY_W - 1));

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic signed [XY_W-1:0]  req_point_x;
   logic signed [XY_W-1:0]  req_point_y;
   logic                    req_last_in_batch;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [1:0]              rsp_outcome;
   logic [IDX_W-1:0]        rsp_entry_index;
   logic signed [XY_W-1:0]  rsp_entry_x;
   logic signed [XY_W-1:0]  rsp_entry_y;
   logic [CNT_BITS-1:0]     rsp_merge_count;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [RAD_W-1:0]        csr_match_radius;
   int                      mismatches;
   int                      outstanding;

   int                      anchor_x[$];
   int                      anchor_y[$];

   always #1 clock = ~clock;

   leader_cluster_running_mean_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .req_last_in_batch (req_last_in_batch),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_outcome       (rsp_outcome),
      .rsp_entry_index   (rsp_entry_index),
      .rsp_entry_x       (rsp_entry_x),
      .rsp_entry_y       (rsp_entry_y),
      .rsp_merge_count   (rsp_merge_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_match_radius  (csr_match_radius)
   );

   cluster_table_checker table_monitor (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .req_last_in_batch (req_last_in_batch),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_outcome       (rsp_outcome),
      .rsp_entry_index   (rsp_entry_index),
      .rsp_entry_x       (rsp_entry_x),
      .rsp_entry_y       (rsp_entry_y),
      .rsp_merge_count   (rsp_merge_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_match_radius  (csr_match_radius),
      .mismatches        (mismatches),
      .outstanding       (outstanding)
   );

   task automatic offer_point(int x, int y, bit last, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_point_x       <= XY_W'(x);
      req_point_y       <= XY_W'(y);
      req_last_in_batch <= last;
      do @(posedge clock); while (!req_ready);
      anchor_x.push_back(x);
      anchor_y.push_back(y);
   endtask

   // Stops offering, waits until every outstanding item has its result, then lets the clock
   // run on so that the block can return to idle.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_radius(logic [RAD_W-1:0] r);
      csr_valid        <= 1'b1;
      csr_match_radius <= r;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(logic [RAD_W-1:0] r, int n);
      int sel;
      int k;
      int spread;
      int x;
      int y;
      bit calm;
      drain_results();
      write_radius(r);
      for (int i = 0; i < n; i++) begin
         sel  = $urandom_range(0, 99);
         calm = (i >= n / 3) && (i < n / 3 + 25);
         if (sel < 70) begin
            // Mostly land near earlier points so that merges dominate; some fall just outside.
            k      = $urandom_range(0, anchor_x.size() - 1);
            spread = (sel < 45) ? int'(r) / 2 : int'(r) + int'(r) / 4 + 1;
            x      = anchor_x[k] + int'($urandom_range(0, 2 * spread)) - spread;
            y      = anchor_y[k] + int'($urandom_range(0, 2 * spread)) - spread;
            x      = (x > XY_MAX) ? XY_MAX : (x < XY_MIN) ? XY_MIN : x;
            y      = (y > XY_MAX) ? XY_MAX : (y < XY_MIN) ? XY_MIN : y;
         end else if (sel < 90) begin
            x = int'($urandom_range(0, (1 << XY_W) - 1)) + XY_MIN;
            y = int'($urandom_range(0, (1 << XY_W) - 1)) + XY_MIN;
         end else begin
            case ($urandom_range(0, 3))
               0: x = XY_MIN;
               1: x = XY_MAX;
               2: x = 0;
               default: x = -1;
            endcase
            case ($urandom_range(0, 3))
               0: y = XY_MIN;
               1: y = XY_MAX;
               2: y = 0;
               default: y = -1;
            endcase
         end
         offer_point(x, y, $urandom_range(0, 4) == 0, calm);
      end
   endtask

   initial begin
      #1_000_000;
      $display("leader_cluster_running_mean_unit verification failed");
      $finish;
   end

   // Result side: random stalls, one long hold-off that backs the block up, and a stretch
   // that takes every result at once.
   initial begin
      int stall;
      int taken;
      rsp_ready = 1'b0;
      taken     = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken == 200) begin
            stall = 400;
         end else if (taken >= 500 && taken < 540) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, 16);
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_point_x       = '0;
      req_point_y       = '0;
      req_last_in_batch = 1'b0;
      csr_valid         = 1'b0;
      csr_match_radius  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset radius. A pending entry is not searched until the batch closes.
      offer_point(0, 0, 1'b0, 1'b0);
      offer_point(0, 0, 1'b0, 1'b0);
      offer_point(10, -10, 1'b1, 1'b0);
      offer_point(100, 100, 1'b0, 1'b0);
      offer_point(XY_MAX, XY_MAX, 1'b0, 1'b0);
      offer_point(XY_MIN, XY_MIN, 1'b1, 1'b0);
      offer_point(XY_MAX - 300, XY_MAX, 1'b0, 1'b0);
      offer_point(XY_MIN + 458, XY_MIN, 1'b0, 1'b0);
      // Each axis inside the radius but the squared sum outside it.
      offer_point(335, -335, 1'b0, 1'b0);
      // Merge with an odd negative sum, closing the batch on a merged point.
      offer_point(333, -333, 1'b1, 1'b0);
      offer_point(-1, 1, 1'b0, 1'b0);

      // A zero radius never matches, even on an exact hit.
      drain_results();
      write_radius('0);
      offer_point(335, -335, 1'b1, 1'b0);

      drain_results();
      write_radius('1);
      offer_point(20000, -20000, 1'b0, 1'b0);
      offer_point(XY_MIN, XY_MAX, 1'b1, 1'b0);

      random_phase(RADIUS_RESET, 120);
      random_phase(16'd3000, 120);
      random_phase(16'd1, 120);
      random_phase('1, 120);
      random_phase(RAD_W'($urandom_range(2, 65534)), 120);
      random_phase('0, 110);
      random_phase(RADIUS_RESET, 120);

      drain_results();
      repeat (100) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("leader_cluster_running_mean_unit verification clean");
      end else begin
         $display("leader_cluster_running_mean_unit verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/lcrm_pkg.sv
rtl/leader_cluster_running_mean_unit.sv
tb/sv/cluster_table_checker.sv
tb/sv/leader_cluster_running_mean_unit_tb.sv
